// ----- rtl/brmi_pkg.sv -----
// ---------------------------------------------------------------------------
// brmi_pkg
// Shared types and constants for the batched running mean image unit.
// ---------------------------------------------------------------------------
package brmi_pkg;

    localparam int SUM_W  = 24;
    localparam int MEAN_W = 16;

    localparam logic [1:0] REG_BATCH_SIZE     = 2'd0;
    localparam logic [1:0] REG_IMAGE_ELEMENTS = 2'd1;
    localparam logic [1:0] REG_DEPTH_FACTOR   = 2'd2;

    typedef struct packed {
        logic start;      // load sample, begin read of both stores
        logic compute;    // read data valid, start arithmetic
        logic commit;     // write back, update counters, load result
    } brmi_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic clear_done;
    } brmi_sts_t;

endpackage

// ----- rtl/batched_running_mean_image_unit.sv -----
// ---------------------------------------------------------------------------
// batched_running_mean_image_unit
// Per-element batch sums and running mean image over a raster sample stream.
// ---------------------------------------------------------------------------
// Sequence: the sample is loaded on the accepting edge, then the states READ,
// WAIT and COMMIT follow, and the result is registered at commit; each sample of
// a batch-completing image adds two serial divisions, waited for in WAIT. Flow:
// a new sample is taken only once the last one is written back, and a held result beat stalls the write back.
// Reset: counters clear at once; a clearing pass zeroes every address of
// both stores before the first sample is taken.
module batched_running_mean_image_unit #(
    parameter int MAX_ELEMENTS = 65536,
    parameter int SAMPLE_BITS  = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  sample,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] element_index,
    output logic [15:0] mean_value,
    output logic        image_end,
    output logic        batch_done,
    output logic [31:0] batches_done
);

    logic [15:0] batch_size_reg;
    logic [16:0] image_elements_reg;
    logic [15:0] depth_factor_reg;
    logic        clearing;
    brmi_pkg::brmi_cmd_t cmd;
    brmi_pkg::brmi_sts_t sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            batch_size_reg     <= 16'd1;
            image_elements_reg <= 17'h10000;
            depth_factor_reg   <= 16'd257;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                brmi_pkg::REG_BATCH_SIZE:     batch_size_reg     <= cfg_data[15:0];
                brmi_pkg::REG_IMAGE_ELEMENTS: image_elements_reg <= cfg_data;
                brmi_pkg::REG_DEPTH_FACTOR:   depth_factor_reg   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    brmi_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .clearing(clearing),
        .cmd(cmd), .sts(sts));

    brmi_datapath #(.MAX_ELEMENTS(MAX_ELEMENTS), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .clearing(clearing),
        .sample(sample), .batch_size(batch_size_reg),
        .image_elements(image_elements_reg), .depth_factor(depth_factor_reg),
        .element_index(element_index), .mean_value(mean_value),
        .image_end(image_end), .batch_done(batch_done),
        .batches_done(batches_done));

endmodule

// ----- rtl/brmi_ram.sv -----
// ---------------------------------------------------------------------------
// brmi_ram
// Single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
module brmi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/brmi_div.sv -----
// ---------------------------------------------------------------------------
// brmi_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module brmi_div #(
    parameter int NW = 48,
    parameter int DW = 33
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          busy,
    output logic [NW-1:0] quo
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] quo_reg;
    logic [DW:0]   rem_reg;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    assign trial = {rem_reg[DW-1:0], quo_reg[NW-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(NW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            if (!diff[DW])
            begin
                rem_reg <= diff;
                quo_reg <= {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[NW-2:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

// ----- rtl/brmi_datapath.sv -----
// ---------------------------------------------------------------------------
// brmi_datapath
// Stores, counters and mean arithmetic for the running mean image unit.
// ---------------------------------------------------------------------------
module brmi_datapath #(
    parameter int MAX_ELEMENTS = 65536,
    parameter int SAMPLE_BITS  = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  brmi_pkg::brmi_cmd_t   cmd,
    output brmi_pkg::brmi_sts_t   sts,
    input  logic                  clearing,
    input  logic [7:0]            sample,
    input  logic [15:0]           batch_size,
    input  logic [16:0]           image_elements,
    input  logic [15:0]           depth_factor,
    output logic [15:0]           element_index,
    output logic [15:0]           mean_value,
    output logic                  image_end,
    output logic                  batch_done,
    output logic [31:0]           batches_done
);

    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int PW = AW + 1;
    localparam int SW = brmi_pkg::SUM_W;
    localparam int MW = brmi_pkg::MEAN_W;
    localparam int SB = (SAMPLE_BITS < 8) ? SAMPLE_BITS : 8;
    localparam int NW = 49;
    localparam int DW = 33;

    typedef enum logic [1:0] {PH_TERM, PH_MEAN} phase_t;

    logic [AW-1:0]  pos_reg, pos_next, addr;
    logic [AW-1:0]  clr_reg;
    logic [15:0]    imgs_reg;
    logic [31:0]    bcnt_reg;
    logic [SW-1:0]  sum_rd;
    logic [MW-1:0]  mean_rd;
    logic [SW-1:0]  sum_reg;
    logic [MW-1:0]  mean_reg;
    logic [SB-1:0]  samp_reg;
    logic           last, completing;
    logic [PW-1:0]  n_eff;
    logic [16:0]    b_eff;
    logic [SW-1:0]  sum_src;
    logic [SW:0]    sum_add;
    logic [SW-1:0]  sum_sat;
    logic           div_start, div_busy;
    logic [NW-1:0]  div_num, div_q;
    logic [DW-1:0]  div_den;
    logic           arith_reg;
    phase_t         ph_reg;
    logic [47:0]    prod_reg;
    logic [MW-1:0]  mean_new;
    logic           we_sum, we_mean;
    logic [SW-1:0]  wsum;
    logic [MW-1:0]  wmean;

    assign n_eff = (image_elements == 17'd0 || 32'(image_elements) > 32'(MAX_ELEMENTS))
                   ? PW'(MAX_ELEMENTS) : PW'(image_elements);
    assign b_eff = (batch_size == 16'd0) ? 17'h10000 : {1'b0, batch_size};
    assign last       = (PW'(pos_reg) + PW'(1)) >= n_eff;
    assign completing = (17'(imgs_reg) + 17'd1) >= b_eff;
    assign pos_next   = last ? '0 : pos_reg + AW'(1);
    assign addr       = clearing ? clr_reg : pos_reg;

    assign sum_src = cmd.compute ? sum_rd : sum_reg;
    assign sum_add = {1'b0, sum_src} + (SW+1)'(samp_reg);
    assign sum_sat = sum_add[SW] ? {SW{1'b1}} : sum_add[SW-1:0];
    assign mean_new = (div_q > NW'({MW{1'b1}})) ? {MW{1'b1}} : div_q[MW-1:0];

    brmi_ram #(.WIDTH(SW), .DEPTH(MAX_ELEMENTS)) u_sum (
        .clk(clk), .we(we_sum), .waddr(addr), .wdata(wsum),
        .raddr(addr), .rdata(sum_rd));
    brmi_ram #(.WIDTH(MW), .DEPTH(MAX_ELEMENTS)) u_mean (
        .clk(clk), .we(we_mean), .waddr(addr), .wdata(wmean),
        .raddr(addr), .rdata(mean_rd));

    brmi_div #(.NW(NW), .DW(DW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
        .den(div_den), .busy(div_busy), .quo(div_q));

    // term = sum*factor/B, then mean' = (mean*(k-1) + term)/k
    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        if (cmd.compute && completing)
        begin
            div_start = 1'b1;
            div_num   = NW'(sum_sat) * NW'(depth_factor);
            div_den   = DW'(b_eff);
        end
        else if (arith_reg && ph_reg == PH_TERM && !div_busy)
        begin
            div_start = 1'b1;
            div_num   = NW'(prod_reg) + div_q;
            div_den   = DW'(bcnt_reg) + DW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arith_reg <= 1'b0;
            ph_reg    <= PH_TERM;
            clr_reg   <= '0;
            pos_reg   <= '0;
            imgs_reg  <= '0;
            bcnt_reg  <= '0;
        end
        else
        begin
            if (clearing)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.compute && completing)
            begin
                arith_reg <= 1'b1;
                ph_reg    <= PH_TERM;
            end
            else if (arith_reg && ph_reg == PH_TERM && !div_busy)
            begin
                ph_reg <= PH_MEAN;
            end
            else if (arith_reg && ph_reg == PH_MEAN && !div_busy)
            begin
                arith_reg <= 1'b0;
            end
            if (cmd.commit)
            begin
                pos_reg <= pos_next;
                if (last)
                begin
                    if (completing)
                    begin
                        imgs_reg <= '0;
                        bcnt_reg <= bcnt_reg + 32'd1;
                    end
                    else
                    begin
                        imgs_reg <= imgs_reg + 16'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            samp_reg <= sample[SB-1:0];
        end
        if (cmd.compute)
        begin
            sum_reg  <= sum_rd;
            mean_reg <= mean_rd;
            prod_reg <= 48'(mean_rd) * 48'(bcnt_reg);
        end
        if (cmd.commit)
        begin
            element_index <= 16'(pos_reg);
            mean_value    <= completing ? mean_new : mean_reg;
            image_end     <= last;
            batch_done    <= last && completing;
            batches_done  <= (last && completing) ? bcnt_reg + 32'd1 : bcnt_reg;
        end
    end

    always_comb
    begin
        we_sum  = clearing || cmd.commit;
        we_mean = clearing || (cmd.commit && completing);
        wsum    = (clearing || completing) ? '0 : sum_sat;
        wmean   = clearing ? '0 : mean_new;
    end

    assign sts.div_busy   = div_busy || arith_reg || (cmd.compute && completing);
    assign sts.clear_done = clearing && (clr_reg == AW'(MAX_ELEMENTS - 1));

endmodule

// ----- rtl/brmi_ctrl.sv -----
// ---------------------------------------------------------------------------
// brmi_ctrl
// Sequencer for clear, read, compute and write back of one sample.
// ---------------------------------------------------------------------------
module brmi_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                clearing,
    output brmi_pkg::brmi_cmd_t cmd,
    input  brmi_pkg::brmi_sts_t sts
);

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_WAIT, S_COMMIT} state_t;

    state_t state_reg;
    logic   ov_reg;
    logic   out_free;

    assign out_free = !ov_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (ov_reg && out_ready)
            begin
                ov_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:  if (sts.clear_done) state_reg <= S_IDLE;
                S_IDLE:   if (in_valid) state_reg <= S_READ;
                S_READ:   state_reg <= S_WAIT;
                S_WAIT:   if (!sts.div_busy) state_reg <= S_COMMIT;
                S_COMMIT:
                begin
                    if (out_free)
                    begin
                        ov_reg    <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign clearing  = (state_reg == S_CLEAR);
    assign cmd.start   = in_valid && (state_reg == S_IDLE);
    assign cmd.compute = (state_reg == S_READ);
    assign cmd.commit  = (state_reg == S_COMMIT) && out_free;

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.compute && cmd.commit)) else $error("compute and commit overlap");
    a_out_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid) else $error("result lost after commit");
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !in_ready) else $error("accept during clear");

endmodule
